// File: sv/i2a_pkg.sv
// Package for the signed 16-bit to decimal ASCII converter.
// Types, ASCII codes and place-value tables shared by the cells and the serializer.
// No dependencies.
package i2a_pkg;

  localparam int unsigned NUM_W      = 16;
  localparam int unsigned NUM_PLACES = 4;
  localparam int unsigned MAX_CHARS  = 6;
  localparam int unsigned CNT_W      = $clog2(MAX_CHARS + 1);
  localparam int unsigned MULT_W     = NUM_W + 1;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef logic [3:0] digit_t;
  typedef logic [MULT_W-1:0] mult_t;
  typedef mult_t [8:0] mult_row_t;

  typedef struct packed {
    logic                         neg;
    logic [NUM_W-1:0]             mag;
    digit_t [NUM_PLACES-1:0]      digs;
  } stage_t;

  typedef logic [MAX_CHARS-1:0][7:0] char_buf_t;

  localparam int unsigned PLACE_WEIGHT [NUM_PLACES] = '{10000, 1000, 100, 10};

  function automatic mult_row_t place_mult(input int unsigned place);
    mult_row_t r;
    for (int unsigned k = 0; k < 9; k++) begin
      r[k] = MULT_W'((k + 1) * PLACE_WEIGHT[place]);
    end
    return r;
  endfunction

endpackage

// File: sv/i2a_cell.sv
// One digit cell of the conversion chain: extracts one decimal digit.
// Compares the running magnitude against the multiples of its place weight.
// Depends on i2a_pkg.
module i2a_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2a_pkg::mult_row_t mult_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2a_pkg::stage_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2a_pkg::stage_t    out_data_o
);

  logic            valid_q;
  i2a_pkg::stage_t data_q, data_d;
  logic [8:0]      ge;
  i2a_pkg::digit_t digit;
  i2a_pkg::mult_t  sub;

  always_comb begin
    digit = '0;
    for (int k = 0; k < 9; k++) begin
      ge[k] = {1'b0, in_data_i.mag} >= mult_i[k];
      digit = digit + i2a_pkg::digit_t'(ge[k]);
    end
    sub = '0;
    if (digit != '0) begin
      sub = mult_i[digit - 4'd1];
    end
    data_d.neg  = in_data_i.neg;
    data_d.mag  = in_data_i.mag - sub[i2a_pkg::NUM_W-1:0];
    data_d.digs = {in_data_i.digs[i2a_pkg::NUM_PLACES-2:0], digit};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: sv/i2a_ser.sv
// Serializer: packs sign and digits, drops leading zeros, sends one char a cycle if ready.
// Loads the next item on the cycle the previous run's last char leaves.
// Depends on i2a_pkg.
module i2a_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  i2a_pkg::stage_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      character_o,
  output logic            last_char_o
);

  i2a_pkg::char_buf_t         buf_q, buf_d, chars;
  logic [i2a_pkg::CNT_W-1:0]  cnt_q, cnt_d, pos;
  logic                       started;
  logic                       load;

  always_comb begin
    chars   = '0;
    pos     = '0;
    started = 1'b0;
    if (in_data_i.neg) begin
      chars[pos] = i2a_pkg::ASCII_MINUS;
      pos        = pos + 1'b1;
    end
    for (int i = i2a_pkg::NUM_PLACES - 1; i >= 0; i--) begin
      if (in_data_i.digs[i] != '0 || started) begin
        chars[pos] = i2a_pkg::ASCII_ZERO + {4'd0, in_data_i.digs[i]};
        pos        = pos + 1'b1;
        started    = 1'b1;
      end
    end
    chars[pos] = i2a_pkg::ASCII_ZERO + {4'd0, in_data_i.mag[3:0]};
    pos        = pos + 1'b1;
  end

  assign in_ready_o = (cnt_q == '0) || (cnt_q == i2a_pkg::CNT_W'(1) && out_ready_i);
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = chars;
      cnt_d = pos;
    end else if (out_valid_o && out_ready_i) begin
      buf_d = {8'h00, buf_q[i2a_pkg::MAX_CHARS-1:1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign character_o = buf_q[0];
  assign last_char_o = cnt_q == i2a_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// File: sv/signed_int16_to_decimal_ascii.sv
// Top level: signed 16-bit integer to decimal ASCII text, one character per output item.
// Chain of four digit cells (10000s down to 10s) feeding the character serializer.
// Depends on i2a_pkg, i2a_cell, i2a_ser.
//
//   channel   signals                                   direction
//   input     in_valid_i, in_ready_o, number_i          number in
//   output    out_valid_o, out_ready_i, character_o,    chars out, last_char_o on final
//             last_char_o
//
// An accepted number passes through each cell register, then the serializer buffer.
// Each number yields 1 to 6 characters, sent one per cycle while out_ready_i is high; the
// cell chain takes a number every cycle unless a stall backs it up.
// Reset clears the valid bits of the cells and the serializer count.
// A stall on the output holds the serializer and backs up the chain cell by cell.
module signed_int16_to_decimal_ascii (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [i2a_pkg::NUM_W-1:0] number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     character_o,
  output logic                           last_char_o
);

  localparam int unsigned N = i2a_pkg::NUM_PLACES;

  i2a_pkg::stage_t [N:0] data;
  logic [N:0]            valid;
  logic [N:0]            ready;

  assign data[0].neg  = number_i[i2a_pkg::NUM_W-1];
  assign data[0].mag  = number_i[i2a_pkg::NUM_W-1] ? (~number_i + 1'b1) : number_i;
  assign data[0].digs = '0;
  assign valid[0]     = in_valid_i;
  assign in_ready_o   = ready[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    i2a_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .mult_i     (i2a_pkg::place_mult(g)),
      .in_valid_i (valid[g]),
      .in_ready_o (ready[g]),
      .in_data_i  (data[g]),
      .out_valid_o(valid[g+1]),
      .out_ready_i(ready[g+1]),
      .out_data_o (data[g+1])
    );
  end

  i2a_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (valid[N]),
    .in_ready_o (ready[N]),
    .in_data_i  (data[N]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_char_o(last_char_o)
  );

endmodule
